[hw/rtl/rrcs_pkg.sv]
`timescale 1ns / 1ps

package rrcs_pkg;

    // default configuration of the top level
    localparam int DEF_NUM_CORES   = 4;
    localparam int DEF_QUEUE_DEPTH = 16;

    // fixed field widths
    localparam int TASK_W    = 8;
    localparam int QUANT_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CORE_OUT_W = 2;

    // register reset values
    localparam logic [QUANT_W-1:0] QUANTUM_LENGTH_RST    = 16'd10;
    localparam logic [QUANT_W-1:0] QUANTUM_DECREMENT_RST = 16'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_DECREMENT = 1'b1;

    // input operation codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result codes
    localparam logic REPORT_ADD   = 1'b0;
    localparam logic REPORT_TICK  = 1'b1;
    localparam logic ADD_OK       = 1'b0;
    localparam logic ADD_DROPPED  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [TASK_W-1:0] new_task_id;
    } t_in;

    typedef struct packed {
        logic                  report_kind;
        logic                  add_status;
        logic [CORE_OUT_W-1:0] core_index;
        logic                  switched;
        logic                  running_valid;
        logic [TASK_W-1:0]     running_task;
        logic                  preempted_valid;
        logic [TASK_W-1:0]     preempted_task;
        logic                  last_report;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic add_op;
        logic tick_op;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_core;
    } t_dp_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK
    } t_state;

endpackage

[hw/rtl/rrcs_ctrl.sv]
`timescale 1ns / 1ps

module rrcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_func,
    input  rrcs_pkg::t_dp_stat i_stat,
    output rrcs_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    rrcs_pkg::t_state r_state;
    rrcs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrcs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_func == rrcs_pkg::FUNC_TICK) ? rrcs_pkg::ST_TICK
                                                              : rrcs_pkg::ST_ADD;
                end
            end
            rrcs_pkg::ST_ADD: begin
                n_state = rrcs_pkg::ST_IDLE;
            end
            rrcs_pkg::ST_TICK: begin
                if (i_stat.last_core) begin
                    n_state = rrcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrcs_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            rrcs_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            rrcs_pkg::ST_ADD: begin
                o_cmd.add_op = 1'b1;
            end
            rrcs_pkg::ST_TICK: begin
                o_cmd.tick_op = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // a tick walks the cores and then releases the block
    a_tick_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrcs_pkg::ST_TICK && i_stat.last_core) |=> !o_busy)
        else $error("tick walk did not end after the last core");

    a_add_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrcs_pkg::ST_ADD) |=> (r_state == rrcs_pkg::ST_IDLE))
        else $error("add did not finish in one cycle");

    a_no_dual_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.add_op && o_cmd.tick_op) && !(o_cmd.load && o_busy))
        else $error("conflicting datapath commands");

endmodule

[hw/rtl/rrcs_dp.sv]
`timescale 1ns / 1ps

module rrcs_dp #(
    parameter int NUM_CORES   = rrcs_pkg::DEF_NUM_CORES,
    parameter int QUEUE_DEPTH = rrcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrcs_pkg::t_in                 i_in,
    input  rrcs_pkg::t_dp_cmd             i_cmd,
    output rrcs_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_valid,
    input  logic [rrcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrcs_pkg::QUANT_W-1:0]  i_cfg_data,
    output logic                          o_res_valid,
    output rrcs_pkg::t_out                o_res
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CORE_W-1:0] CORE_LAST = CORE_W'(NUM_CORES - 1);

    // configuration registers
    logic [rrcs_pkg::QUANT_W-1:0] r_qlen;
    logic [rrcs_pkg::QUANT_W-1:0] r_qdec;

    // ready queue
    logic [rrcs_pkg::TASK_W-1:0] r_mem [QUEUE_DEPTH];
    logic [rrcs_pkg::TASK_W-1:0] r_head_data;
    logic [PTR_W-1:0]            r_head, n_head;
    logic [PTR_W-1:0]            r_tail, n_tail;
    logic [CNT_W-1:0]            r_count, n_count;

    // per-core state
    logic [rrcs_pkg::TASK_W-1:0]  r_task  [NUM_CORES];
    logic [rrcs_pkg::QUANT_W-1:0] r_qleft [NUM_CORES];
    logic [NUM_CORES-1:0]         r_busy;
    logic [CORE_W-1:0]            r_core;

    // latched input word and result register
    rrcs_pkg::t_in  r_in;
    rrcs_pkg::t_out r_res, n_res;
    logic           r_res_valid, n_res_valid;

    // per-step decisions
    logic                         push, pop;
    logic [rrcs_pkg::TASK_W-1:0]  push_data;
    logic                         core_we;
    logic                         new_busy;
    logic [rrcs_pkg::TASK_W-1:0]  new_task;
    logic [rrcs_pkg::QUANT_W-1:0] new_qleft;
    logic                         cur_busy;
    logic [rrcs_pkg::TASK_W-1:0]  cur_task;
    logic [rrcs_pkg::QUANT_W-1:0] cur_qleft;
    logic                         q_nonempty;
    logic [31:0]                  core_wide;

    assign cur_busy   = r_busy[r_core];
    assign cur_task   = r_task[r_core];
    assign cur_qleft  = r_qleft[r_core];
    assign q_nonempty = (r_count != '0);
    assign core_wide  = 32'(r_core);

    assign o_stat.last_core = (r_core == CORE_LAST);
    assign o_res_valid      = r_res_valid;
    assign o_res            = r_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= rrcs_pkg::QUANTUM_LENGTH_RST;
            r_qdec <= rrcs_pkg::QUANTUM_DECREMENT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rrcs_pkg::CFG_QUANTUM_LENGTH:    r_qlen <= i_cfg_data;
                rrcs_pkg::CFG_QUANTUM_DECREMENT: r_qdec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // add answer or one core's tick step
    always_comb begin
        push        = 1'b0;
        pop         = 1'b0;
        push_data   = cur_task;
        core_we     = 1'b0;
        new_busy    = cur_busy;
        new_task    = cur_task;
        new_qleft   = cur_qleft;
        n_res       = '0;
        n_res_valid = 1'b0;

        if (i_cmd.add_op) begin
            n_res_valid       = 1'b1;
            n_res.report_kind = rrcs_pkg::REPORT_ADD;
            n_res.last_report = 1'b1;
            if (r_count < CNT_FULL) begin
                push            = 1'b1;
                push_data       = r_in.new_task_id;
                n_res.add_status = rrcs_pkg::ADD_OK;
            end else begin
                n_res.add_status = rrcs_pkg::ADD_DROPPED;
            end
        end else if (i_cmd.tick_op) begin
            core_we = 1'b1;
            if (cur_busy) begin
                if (r_qdec >= cur_qleft) begin
                    // quantum ran out: rotate with the queue head if any
                    if (q_nonempty) begin
                        pop                   = 1'b1;
                        push                  = 1'b1;
                        push_data             = cur_task;
                        new_task              = r_head_data;
                        n_res.switched        = 1'b1;
                        n_res.preempted_valid = 1'b1;
                        n_res.preempted_task  = cur_task;
                    end
                    new_qleft = r_qlen;
                end else begin
                    new_qleft = cur_qleft - r_qdec;
                end
            end else if (q_nonempty) begin
                // idle core picks up the head
                pop            = 1'b1;
                new_busy       = 1'b1;
                new_task       = r_head_data;
                new_qleft      = r_qlen;
                n_res.switched = 1'b1;
            end
            n_res_valid         = 1'b1;
            n_res.report_kind   = rrcs_pkg::REPORT_TICK;
            n_res.add_status    = rrcs_pkg::ADD_OK;
            n_res.core_index    = core_wide[rrcs_pkg::CORE_OUT_W-1:0];
            n_res.running_valid = new_busy;
            n_res.running_task  = new_busy ? new_task : '0;
            n_res.last_report   = (r_core == CORE_LAST);
        end
    end

    // queue pointers
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        if (pop) begin
            n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
        end
        if (push) begin
            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // queue memory, head word prefetched with write-through
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= push_data;
        end
        if (push && (r_tail == n_head)) begin
            r_head_data <= push_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    // core control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_core <= '0;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_qleft[i] <= '0;
            end
        end else begin
            if (core_we) begin
                r_busy[r_core]  <= new_busy;
                r_qleft[r_core] <= new_qleft;
            end
            if (i_cmd.load) begin
                r_core <= '0;
            end else if (i_cmd.tick_op) begin
                r_core <= (r_core == CORE_LAST) ? '0 : r_core + 1'b1;
            end
        end
    end

    // core task ids and input word
    always_ff @(posedge i_clk) begin
        if (core_we) begin
            r_task[r_core] <= new_task;
        end
        if (i_cmd.load) begin
            r_in <= i_in;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_tick_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_op |=> (r_count <= $past(r_count)))
        else $error("queue grew during a tick");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_op && o_stat.last_core) |=> (r_res_valid && r_res.last_report))
        else $error("last core word not marked");

    a_core_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_core <= CORE_LAST)
        else $error("core counter out of range");

endmodule

[hw/rtl/round_robin_core_scheduler.sv]
`timescale 1ns / 1ps

// Round-robin time-slice scheduler. A command is taken when i_start is high and
// o_busy is low. An add command (func 0) enqueues new_task_id and gives one
// result word, registered from the ST_ADD state, with add_status set if the
// queue was full; the block is busy while in ST_ADD. A tick command (func 1)
// walks the cores one per cycle and gives one word per core, core 0 first, the
// last word marked by last_report; it keeps the block busy in ST_TICK until the
// last core is done, since the cores share a single core update path and the
// ready queue has one read port. Results appear on o_res for exactly one
// cycle with o_res_valid high and cannot be held off, so the receiver must take
// every word as it comes. The configuration port always accepts and must only
// be written while the block is idle.
module round_robin_core_scheduler #(
    parameter int NUM_CORES   = rrcs_pkg::DEF_NUM_CORES,
    parameter int QUEUE_DEPTH = rrcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rrcs_pkg::t_in                  i_in,
    output logic                           o_res_valid,
    output rrcs_pkg::t_out                 o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rrcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrcs_pkg::QUANT_W-1:0]   i_cfg_data
);

    rrcs_pkg::t_dp_cmd  cmd;
    rrcs_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    rrcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_in.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // queue, core state and result register
    rrcs_dp #(
        .NUM_CORES   (NUM_CORES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
